// ===== design/rc5_block_cipher_unit_macros.svh =====
// Assertion macros shared by the cipher unit.
`ifndef RC5_BLOCK_CIPHER_UNIT_MACROS_SVH
`define RC5_BLOCK_CIPHER_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define RC5_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define RC5_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define RC5_ASSERT_IMPL(lbl, ante, cons, msg)
`define RC5_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== design/rc5_pkg.sv =====
package rc5_pkg;

    localparam logic [31:0] MAGIC_P = 32'hb7e15163;
    localparam logic [31:0] MAGIC_Q = 32'h9e3779b9;

    localparam logic CFG_KEY_LOW  = 1'b0;
    localparam logic CFG_KEY_HIGH = 1'b1;

    typedef enum logic [2:0] {
        ALU_ADD,
        ALU_SUB,
        ALU_ENC,
        ALU_DEC,
        ALU_MIX3,
        ALU_MIXV
    } alu_op_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INIT,
        S_MIX_RD,
        S_MIX_A,
        S_MIX_B,
        S_CRD,
        S_CRUN,
        S_OUT
    } state_t;

endpackage

// ===== design/rc5_ram.sv =====
module rc5_ram #(
    parameter int DEPTH  = 26,
    parameter int ADDR_W = 5
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [31:0]       wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [31:0]       rdata
);

    logic [31:0] mem [DEPTH];
    logic [31:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/rc5_alu.sv =====
module rc5_alu (
    input  rc5_pkg::alu_op_t op,
    input  logic [31:0]      x,
    input  logic [31:0]      y,
    input  logic [31:0]      k,
    output logic [31:0]      res
);

    import rc5_pkg::*;

    logic [31:0] sum_xy;
    logic [31:0] sum_all;

    function automatic logic [31:0] rotl32(input logic [31:0] v, input logic [4:0] n);
        logic [63:0] t;
        t = {v, v} << n;
        return t[63:32];
    endfunction

    function automatic logic [31:0] rotr32(input logic [31:0] v, input logic [4:0] n);
        logic [63:0] t;
        t = {v, v} >> n;
        return t[31:0];
    endfunction

    assign sum_xy  = x + y;
    assign sum_all = sum_xy + k;

    always_comb
    begin
        case (op)
            ALU_ADD:  res = x + k;
            ALU_SUB:  res = x - k;
            ALU_ENC:  res = rotl32(x ^ y, y[4:0]) + k;
            ALU_DEC:  res = rotr32(x - k, y[4:0]) ^ y;
            ALU_MIX3: res = rotl32(sum_all, 5'd3);
            ALU_MIXV: res = rotl32(sum_all, sum_xy[4:0]);
            default:  res = x;
        endcase
    end

endmodule

// ===== design/rc5_block_cipher_unit.sv =====
// RC5-32 block cipher with a 128-bit key written as two 64-bit registers
// (key_low at byte address 0, key_high at byte address 8). A key write marks
// the subkey table stale, and the next accepted beat first rebuilds it: a
// fill of the table with the magic constants, then the key mixing. A beat
// then occupies the block from acceptance until its result is registered,
// because one shared adder-rotator unit performs one half-round per cycle
// and the subkey memory, with its single registered read port, supplies one
// word per cycle. A new beat is taken in the cycle after that, even while the
// previous result waits.
`include "rc5_block_cipher_unit_macros.svh"

module rc5_block_cipher_unit #(
    parameter int ROUNDS = 12
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        mode,
    input  logic [31:0] in_word_a,
    input  logic [31:0] in_word_b,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] out_word_a,
    output logic [31:0] out_word_b
);

    import rc5_pkg::*;

    localparam int TABLE_WORDS = 2 * ROUNDS + 2;
    localparam int MIX_PASSES  = 3 * TABLE_WORDS;
    localparam int IDX_W       = $clog2(TABLE_WORDS);
    localparam int PASS_W      = $clog2(MIX_PASSES + 1);
    localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(TABLE_WORDS - 1);
    localparam logic [PASS_W-1:0] LAST_PASS = PASS_W'(MIX_PASSES - 1);

    state_t state_reg, state_next;

    logic [63:0] key_low_reg, key_low_next;
    logic [63:0] key_high_reg, key_high_next;
    logic        table_ready_reg, table_ready_next;
    logic        mode_reg, mode_next;
    logic [31:0] da_reg, da_next;
    logic [31:0] db_reg, db_next;
    logic [31:0] xa_reg, xa_next;
    logic [31:0] xb_reg, xb_next;
    logic [31:0] kw_reg [4];
    logic [31:0] kw_next [4];
    logic [IDX_W-1:0]  t_reg, t_next;
    logic [1:0]        w_reg, w_next;
    logic [PASS_W-1:0] pass_reg, pass_next;
    logic [IDX_W-1:0]  kidx_reg, kidx_next;
    logic        out_valid_reg, out_valid_next;
    logic [31:0] out_a_reg, out_a_next;
    logic [31:0] out_b_reg, out_b_next;

    logic             cfg_wr;
    logic             in_fire;
    logic             out_free;
    logic             mix_last;
    logic             crun_last;
    logic [IDX_W-1:0] t_inc;

    alu_op_t     alu_op;
    logic [31:0] alu_x;
    logic [31:0] alu_y;
    logic [31:0] alu_k;
    logic [31:0] alu_res;

    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic [31:0]      mem_wdata;
    logic [IDX_W-1:0] mem_raddr;
    logic [31:0]      mem_rdata;

    rc5_alu u_alu (
        .op  (alu_op),
        .x   (alu_x),
        .y   (alu_y),
        .k   (alu_k),
        .res (alu_res)
    );

    rc5_ram #(
        .DEPTH  (TABLE_WORDS),
        .ADDR_W (IDX_W)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign cfg_wr    = psel & penable & pwrite;
    assign pready    = 1'b1;
    assign prdata    = (paddr[3] == CFG_KEY_HIGH) ? key_high_reg : key_low_reg;
    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid & in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign mix_last  = (pass_reg == LAST_PASS);
    assign crun_last = mode_reg ? (kidx_reg == '0) : (kidx_reg == LAST_IDX);
    assign t_inc     = (t_reg == LAST_IDX) ? '0 : t_reg + 1'b1;

    assign out_valid  = out_valid_reg;
    assign out_word_a = out_a_reg;
    assign out_word_b = out_b_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = table_ready_reg ? S_CRD : S_INIT;
                end
            end
            S_INIT:
            begin
                if (t_reg == LAST_IDX)
                begin
                    state_next = S_MIX_RD;
                end
            end
            S_MIX_RD: state_next = S_MIX_A;
            S_MIX_A:  state_next = S_MIX_B;
            S_MIX_B:  state_next = mix_last ? S_CRD : S_MIX_A;
            S_CRD:    state_next = S_CRUN;
            S_CRUN:
            begin
                if (crun_last)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        key_low_next     = key_low_reg;
        key_high_next    = key_high_reg;
        table_ready_next = table_ready_reg;
        mode_next        = mode_reg;
        da_next          = da_reg;
        db_next          = db_reg;
        xa_next          = xa_reg;
        xb_next          = xb_reg;
        kw_next          = kw_reg;
        t_next           = t_reg;
        w_next           = w_reg;
        pass_next        = pass_reg;
        kidx_next        = kidx_reg;
        out_valid_next   = out_valid_reg;
        out_a_next       = out_a_reg;
        out_b_next       = out_b_reg;

        alu_op    = ALU_ADD;
        alu_x     = xa_reg;
        alu_y     = xb_reg;
        alu_k     = mem_rdata;
        mem_we    = 1'b0;
        mem_waddr = t_reg;
        mem_wdata = alu_res;
        mem_raddr = t_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    mode_next = mode;
                    da_next   = in_word_a;
                    db_next   = in_word_b;
                    t_next    = '0;
                    xa_next   = MAGIC_P;
                end
            end
            S_INIT:
            begin
                alu_op    = ALU_ADD;
                alu_k     = MAGIC_Q;
                mem_we    = 1'b1;
                mem_wdata = xa_reg;
                xa_next   = alu_res;
                t_next    = t_inc;
                if (t_reg == LAST_IDX)
                begin
                    xa_next    = '0;
                    xb_next    = '0;
                    w_next     = '0;
                    pass_next  = '0;
                    kw_next[0] = key_low_reg[31:0];
                    kw_next[1] = key_low_reg[63:32];
                    kw_next[2] = key_high_reg[31:0];
                    kw_next[3] = key_high_reg[63:32];
                end
            end
            S_MIX_RD:
            begin
                mem_raddr = t_reg;
            end
            S_MIX_A:
            begin
                alu_op  = ALU_MIX3;
                mem_we  = 1'b1;
                xa_next = alu_res;
            end
            S_MIX_B:
            begin
                alu_op          = ALU_MIXV;
                alu_k           = kw_reg[w_reg];
                xb_next         = alu_res;
                kw_next[w_reg]  = alu_res;
                w_next          = w_reg + 1'b1;
                t_next          = t_inc;
                mem_raddr       = t_inc;
                pass_next       = pass_reg + 1'b1;
                if (mix_last)
                begin
                    table_ready_next = 1'b1;
                end
            end
            S_CRD:
            begin
                kidx_next = mode_reg ? LAST_IDX : '0;
                mem_raddr = kidx_next;
            end
            S_CRUN:
            begin
                alu_x = kidx_reg[0] ? db_reg : da_reg;
                alu_y = kidx_reg[0] ? da_reg : db_reg;
                if (kidx_reg[IDX_W-1:1] == '0)
                begin
                    alu_op = mode_reg ? ALU_SUB : ALU_ADD;
                end
                else
                begin
                    alu_op = mode_reg ? ALU_DEC : ALU_ENC;
                end
                if (kidx_reg[0])
                begin
                    db_next = alu_res;
                end
                else
                begin
                    da_next = alu_res;
                end
                if (!crun_last)
                begin
                    kidx_next = mode_reg ? kidx_reg - 1'b1 : kidx_reg + 1'b1;
                end
                mem_raddr = kidx_next;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_a_next     = da_reg;
                    out_b_next     = db_reg;
                end
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase

        if (cfg_wr)
        begin
            if (paddr[3] == CFG_KEY_HIGH)
            begin
                key_high_next = pwdata;
            end
            else
            begin
                key_low_next = pwdata;
            end
            table_ready_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            key_low_reg     <= '0;
            key_high_reg    <= '0;
            table_ready_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
            t_reg           <= '0;
            w_reg           <= '0;
            pass_reg        <= '0;
            kidx_reg        <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            key_low_reg     <= key_low_next;
            key_high_reg    <= key_high_next;
            table_ready_reg <= table_ready_next;
            out_valid_reg   <= out_valid_next;
            t_reg           <= t_next;
            w_reg           <= w_next;
            pass_reg        <= pass_next;
            kidx_reg        <= kidx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg  <= mode_next;
        da_reg    <= da_next;
        db_reg    <= db_next;
        xa_reg    <= xa_next;
        xb_reg    <= xb_next;
        kw_reg    <= kw_next;
        out_a_reg <= out_a_next;
        out_b_reg <= out_b_next;
    end

    `RC5_ASSERT_NEXT(a_cfg_stales_table, cfg_wr, !table_ready_reg,
        "Key write did not mark the subkey table stale.")
    `RC5_ASSERT_NEXT(a_mix_end_ready, (state_reg == S_MIX_B) && mix_last && !cfg_wr,
        table_ready_reg && (state_reg == S_CRD), "Key schedule end did not arm the table.")
    `RC5_ASSERT_IMPL(a_kidx_range, state_reg == S_CRUN, kidx_reg <= LAST_IDX,
        "Subkey index left the table during a block.")
    `RC5_ASSERT_NEXT(a_out_loaded, (state_reg == S_OUT) && out_ready, out_valid_reg,
        "Finished block was not presented on the output.")

endmodule

// ===== test/tb_rc5_block_cipher_unit.sv =====
module tb_rc5_block_cipher_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import rc5_pkg::*;

    localparam int ROUNDS = 12;
    localparam int TABLE_WORDS = 2 * ROUNDS + 2;
    localparam int MIX_PASSES = 3 * TABLE_WORDS;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES = 2 * ROUNDS + 12;
    localparam int KEY_PHASES = 8;
    localparam int BLOCKS_PER_PHASE = 216;

    localparam logic MODE_ENC = 1'b0;
    localparam logic MODE_DEC = 1'b1;

    typedef struct packed {
        logic        mode;
        logic [31:0] a;
        logic [31:0] b;
    } cipher_block_t;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
    } halves_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;
    logic        in_valid;
    logic        in_ready;
    logic        mode;
    logic [31:0] in_word_a;
    logic [31:0] in_word_b;
    logic        out_valid;
    logic        out_ready;
    logic [31:0] out_word_a;
    logic [31:0] out_word_b;

    logic [63:0] key_lo_model;
    logic [63:0] key_hi_model;
    logic [31:0] subkeys [TABLE_WORDS];
    logic        subkeys_fresh;

    cipher_block_t pending_blocks[$];
    halves_t       expected_halves[$];

    int sender_idle_pct;
    int receiver_stall_pct;
    int unsigned mismatches;
    int unsigned enc_sent;
    int unsigned dec_sent;
    int unsigned results_seen;
    int unsigned key_writes;
    int unsigned quiet_cycles;

    rc5_block_cipher_unit #(
        .ROUNDS(ROUNDS)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .mode(mode),
        .in_word_a(in_word_a),
        .in_word_b(in_word_b),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_word_a(out_word_a),
        .out_word_b(out_word_b)
    );

    always #5 clk = ~clk;

    function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] n);
        return (x << n) | (x >> (6'd32 - n));
    endfunction

    function automatic logic [31:0] rotr32(input logic [31:0] x, input logic [4:0] n);
        return (x >> n) | (x << (6'd32 - n));
    endfunction

    function automatic void expand_subkeys();
        logic [31:0] kw [4];
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] ab;
        int          t;
        int          w;
        kw[0] = key_lo_model[31:0];
        kw[1] = key_lo_model[63:32];
        kw[2] = key_hi_model[31:0];
        kw[3] = key_hi_model[63:32];
        subkeys[0] = MAGIC_P;
        for (int i = 1; i < TABLE_WORDS; i++)
        begin
            subkeys[i] = subkeys[i - 1] + MAGIC_Q;
        end
        a = '0;
        b = '0;
        t = 0;
        w = 0;
        for (int pass = 0; pass < MIX_PASSES; pass++)
        begin
            a = rotl32(subkeys[t] + a + b, 5'd3);
            subkeys[t] = a;
            ab = a + b;
            b = rotl32(kw[w] + a + b, ab[4:0]);
            kw[w] = b;
            t = (t + 1 < TABLE_WORDS) ? t + 1 : 0;
            w = (w + 1) % 4;
        end
        subkeys_fresh = 1'b1;
    endfunction

    function automatic halves_t rc5_transform(input logic m, input logic [31:0] a_in,
                                              input logic [31:0] b_in);
        logic [31:0] a;
        logic [31:0] b;
        halves_t     res;
        if (!subkeys_fresh)
            expand_subkeys();
        a = a_in;
        b = b_in;
        if (m == MODE_ENC)
        begin
            a = a + subkeys[0];
            b = b + subkeys[1];
            for (int r = 1; r <= ROUNDS; r++)
            begin
                a = rotl32(a ^ b, b[4:0]) + subkeys[2 * r];
                b = rotl32(b ^ a, a[4:0]) + subkeys[2 * r + 1];
            end
        end
        else
        begin
            for (int r = ROUNDS; r >= 1; r--)
            begin
                b = rotr32(b - subkeys[2 * r + 1], a[4:0]) ^ a;
                a = rotr32(a - subkeys[2 * r], b[4:0]) ^ b;
            end
            b = b - subkeys[1];
            a = a - subkeys[0];
        end
        res.a = a;
        res.b = b;
        return res;
    endfunction

    function automatic logic [31:0] pick_word();
        case ($urandom_range(9))
            0: return 32'h0;
            1: return 32'hffff_ffff;
            2: return 32'h1 << $urandom_range(31);
            3: return ~(32'h1 << $urandom_range(31));
            default: return $urandom;
        endcase
    endfunction

    function automatic void push_block(input logic m, input logic [31:0] a,
                                       input logic [31:0] b);
        cipher_block_t blk;
        blk.mode = m;
        blk.a = a;
        blk.b = b;
        pending_blocks.push_back(blk);
    endfunction

    // A block followed by its inverse, so the second beat must restore the first.
    function automatic void push_round_trip(input logic m, input logic [31:0] a,
                                            input logic [31:0] b);
        halves_t fwd;
        fwd = rc5_transform(m, a, b);
        push_block(m, a, b);
        push_block(~m, fwd.a, fwd.b);
    endfunction

    task automatic wait_drained();
        while (pending_blocks.size() != 0 || in_valid || expected_halves.size() != 0)
            @(posedge clk);
    endtask

    task automatic key_write(input logic idx, input logic [63:0] value);
        logic [63:0] readback;
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (idx == CFG_KEY_LOW)
            key_lo_model = value;
        else
            key_hi_model = value;
        subkeys_fresh = 1'b0;
        key_writes++;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        readback = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        if (readback !== value)
        begin
            $display("%0t: key register %0d readback mismatch, expected %016h, got %016h",
                     $time, idx, value, readback);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : drive_blocks
        cipher_block_t nxt;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            mode <= MODE_ENC;
            in_word_a <= '0;
            in_word_b <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                expected_halves.push_back(rc5_transform(mode, in_word_a, in_word_b));
                if (mode == MODE_DEC)
                    dec_sent++;
                else
                    enc_sent++;
            end
            if (!in_valid || in_ready)
            begin
                if (pending_blocks.size() != 0 && $urandom_range(99) >= sender_idle_pct)
                begin
                    nxt = pending_blocks.pop_front();
                    in_valid <= 1'b1;
                    mode <= nxt.mode;
                    in_word_a <= nxt.a;
                    in_word_b <= nxt.b;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : check_results
        halves_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (expected_halves.size() == 0)
                begin
                    $display("%0t: unexpected result beat, expected none, got %08h %08h",
                             $time, out_word_a, out_word_b);
                    mismatches++;
                end
                else
                begin
                    want = expected_halves.pop_front();
                    if (out_word_a !== want.a)
                    begin
                        $display("%0t: out_word_a mismatch, expected %08h, got %08h",
                                 $time, want.a, out_word_a);
                        mismatches++;
                    end
                    if (out_word_b !== want.b)
                    begin
                        $display("%0t: out_word_b mismatch, expected %08h, got %08h",
                                 $time, want.b, out_word_b);
                        mismatches++;
                    end
                end
            end
            out_ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || psel)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no beat moved for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("tb_rc5_block_cipher_unit NOT OK");
                $finish;
            end
        end
    end

    initial
    begin
        int unsigned queued;
        rst_n <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        mismatches = 0;
        enc_sent = 0;
        dec_sent = 0;
        results_seen = 0;
        key_writes = 0;
        quiet_cycles = 0;
        key_lo_model = '0;
        key_hi_model = '0;
        subkeys_fresh = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // The reset key is all zeros, so the first beat expands the zero key.
        push_block(MODE_ENC, 32'h0, 32'h0);
        push_block(MODE_ENC, 32'hffff_ffff, 32'hffff_ffff);
        push_block(MODE_ENC, 32'h8000_0000, 32'h0000_0001);
        push_block(MODE_ENC, 32'h0000_0001, 32'h8000_0000);
        push_block(MODE_ENC, 32'h0, 32'hffff_ffff);
        push_block(MODE_ENC, 32'h5555_5555, 32'haaaa_aaaa);
        push_block(MODE_DEC, 32'h0, 32'h0);
        push_block(MODE_DEC, 32'hffff_ffff, 32'hffff_ffff);
        push_block(MODE_DEC, 32'heedb_a521, 32'h6d8f_4b15);
        push_block(MODE_DEC, 32'hffff_ffff, 32'h0);
        wait_drained();

        key_write(CFG_KEY_LOW, {64{1'b1}});
        key_write(CFG_KEY_HIGH, {64{1'b1}});
        push_block(MODE_ENC, 32'h0, 32'h0);
        push_block(MODE_DEC, 32'h0, 32'h0);
        push_block(MODE_ENC, 32'hffff_ffff, 32'hffff_ffff);
        push_block(MODE_DEC, 32'hffff_ffff, 32'hffff_ffff);
        push_round_trip(MODE_ENC, 32'h0123_4567, 32'h89ab_cdef);
        push_round_trip(MODE_DEC, 32'hdead_beef, 32'h0000_001f);
        wait_drained();

        for (int ph = 0; ph < KEY_PHASES; ph++)
        begin
            case (ph)
                0: key_write(CFG_KEY_LOW, {$urandom, $urandom});
                1: key_write(CFG_KEY_HIGH, 64'h0);
                2:
                begin
                    key_write(CFG_KEY_LOW, 64'h0);
                    key_write(CFG_KEY_HIGH, 64'h0);
                end
                4: key_write(CFG_KEY_LOW, key_lo_model);
                5:
                begin
                    key_write(CFG_KEY_LOW, 64'h0);
                    key_write(CFG_KEY_HIGH, {64{1'b1}});
                end
                default:
                begin
                    key_write(CFG_KEY_HIGH, {$urandom, $urandom});
                    key_write(CFG_KEY_LOW, {$urandom, $urandom});
                end
            endcase
            case (ph % 4)
                0:
                begin
                    sender_idle_pct = 0;
                    receiver_stall_pct = 0;
                end
                1:
                begin
                    sender_idle_pct = 47;
                    receiver_stall_pct = 0;
                end
                2:
                begin
                    sender_idle_pct = 0;
                    receiver_stall_pct = 47;
                end
                default:
                begin
                    sender_idle_pct = 15;
                    receiver_stall_pct = 15;
                end
            endcase
            queued = 0;
            while (queued < BLOCKS_PER_PHASE)
            begin
                if ($urandom_range(9) < 7)
                begin
                    push_round_trip(1'($urandom_range(1)), pick_word(), pick_word());
                    queued += 2;
                end
                else
                begin
                    push_block(1'($urandom_range(1)), pick_word(), pick_word());
                    queued++;
                end
            end
            wait_drained();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("Sent %0d encrypt and %0d decrypt beats, checked %0d results.",
                 enc_sent, dec_sent, results_seen);
        $display("Made %0d key writes, including all-zero and all-one keys, under four idle mixes.",
                 key_writes);
        if (mismatches == 0)
            $display("tb_rc5_block_cipher_unit OK");
        else
            $display("tb_rc5_block_cipher_unit NOT OK");
        $finish;
    end

endmodule
